FILE: hdl/complex_quaternary_weight_dot_unit_macros.svh
`ifndef COMPLEX_QUATERNARY_WEIGHT_DOT_UNIT_MACROS_SVH
`define COMPLEX_QUATERNARY_WEIGHT_DOT_UNIT_MACROS_SVH

// Check a consequence in the same cycle as its trigger.
`define CQWD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its trigger.
`define CQWD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/cqwd_pkg.sv
package cqwd_pkg;

	localparam int LANES  = 4;
	localparam int ACT_W  = 16;
	localparam int CODE_W = 2;
	localparam int CODES_W = LANES * CODE_W;
	localparam int PROD_W = 2 * ACT_W;
	// four terms of at most 2^30 in magnitude need two more bits
	localparam int TSUM_W = PROD_W + 2;
	localparam int OUT_W  = 48;

	typedef logic signed [ACT_W-1:0]  act_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [TSUM_W-1:0] tsum_t;
	typedef logic signed [OUT_W-1:0]  sum_t;

	// weight code meaning
	typedef enum logic [CODE_W-1:0] {
		CODE_NEG_ONE = 2'b00,
		CODE_POS_ONE = 2'b01,
		CODE_NEG_I   = 2'b10,
		CODE_POS_I   = 2'b11
	} code_t;

	// signed product terms of one item, handed to the accumulator side
	typedef struct packed {
		logic              valid;
		logic              last;
		prod_t [LANES-1:0] re;
		prod_t [LANES-1:0] im;
	} term_bus_t;

endpackage

FILE: hdl/cqwd_item_if.sv
interface cqwd_item_if import cqwd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CODES_W-1:0]   weight_codes;
	act_t                 act_re0;
	act_t                 act_im0;
	act_t                 act_re1;
	act_t                 act_im1;
	act_t                 act_re2;
	act_t                 act_im2;
	act_t                 act_re3;
	act_t                 act_im3;
	act_t                 scale_re;
	act_t                 scale_im;
	logic                 last_of_row;

	modport source (
		output valid, weight_codes, act_re0, act_im0, act_re1, act_im1,
		output act_re2, act_im2, act_re3, act_im3, scale_re, scale_im, last_of_row,
		input  ready
	);

	modport sink (
		input  valid, weight_codes, act_re0, act_im0, act_re1, act_im1,
		input  act_re2, act_im2, act_re3, act_im3, scale_re, scale_im, last_of_row,
		output ready
	);
endinterface

FILE: hdl/cqwd_result_if.sv
interface cqwd_result_if import cqwd_pkg::*; ();
	logic valid;
	logic ready;
	sum_t sum_re;
	sum_t sum_im;

	modport source (
		output valid, sum_re, sum_im,
		input  ready
	);

	modport sink (
		input  valid, sum_re, sum_im,
		output ready
	);
endinterface

FILE: hdl/complex_quaternary_weight_dot_unit.sv
// Channel   Modport  Payload                                           Role
// item      sink     weight_codes, act_re0..act_im3, scale_re/im, last  one packed weight byte
// result    source   sum_re, sum_im (48-bit Q18.30)                     row sum on last_of_row
//
// One request per cycle while no full result register stalls the pipe: the four complex
// products run in parallel (eight 16x16 multipliers) with a register after the multipliers
// and after the term adders. A row sum is registered in the result register before it is presented.
// Reset clears the accumulator and all stage valid bits; no clearing pass.
// A full result register stalls a row-ending request in the last stage, and the
// requests behind it wait; requests ahead of it flow.
module complex_quaternary_weight_dot_unit import cqwd_pkg::*; #(
	parameter int ACC_WIDTH = 48
) (
	input  logic          clk,
	input  logic          arst_n,
	cqwd_item_if.sink     item,
	cqwd_result_if.source result
);

	term_bus_t terms;
	logic      take;

	// products and signs
	cqwd_mult u_mult (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.take   (take),
		.terms  (terms)
	);

	// term sums, saturating accumulator and result register
	cqwd_accum #(
		.ACC_WIDTH (ACC_WIDTH)
	) u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.terms  (terms),
		.take   (take),
		.result (result)
	);

endmodule

FILE: hdl/cqwd_mult.sv
module cqwd_mult import cqwd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	cqwd_item_if.sink  item,
	input  logic       take,
	output term_bus_t  terms
);

	logic               valid_s1;
	logic               last_s1;
	logic [CODES_W-1:0] codes_s1;
	act_t [LANES-1:0]   re_s1;
	act_t [LANES-1:0]   im_s1;
	act_t               scale_re_s1;
	act_t               scale_im_s1;

	logic               valid_s2;
	logic               last_s2;
	prod_t [LANES-1:0]  re_s2;
	prod_t [LANES-1:0]  im_s2;

	act_t [LANES-1:0]   act_re_in;
	act_t [LANES-1:0]   act_im_in;
	prod_t [LANES-1:0]  re_c;
	prod_t [LANES-1:0]  im_c;

	logic               s1_en;
	logic               s2_en;

	// collapse bubbles: a stage loads when empty or when it drains
	assign s2_en      = !valid_s2 || take;
	assign s1_en      = !valid_s1 || s2_en;
	assign item.ready = s1_en;

	assign act_re_in[0] = item.act_re0;
	assign act_im_in[0] = item.act_im0;
	assign act_re_in[1] = item.act_re1;
	assign act_im_in[1] = item.act_im1;
	assign act_re_in[2] = item.act_re2;
	assign act_im_in[2] = item.act_im2;
	assign act_re_in[3] = item.act_re3;
	assign act_im_in[3] = item.act_im3;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_en) begin
				valid_s1 <= item.valid;
			end
			if (s2_en) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// capture the request
	always_ff @(posedge clk) begin
		if (s1_en && item.valid) begin
			last_s1     <= item.last_of_row;
			codes_s1    <= item.weight_codes;
			re_s1       <= act_re_in;
			im_s1       <= act_im_in;
			scale_re_s1 <= item.scale_re;
			scale_im_s1 <= item.scale_im;
		end
	end

	// multiply each conjugated activation by its code and scale
	always_comb begin
		code_t code;
		act_t  scale;
		prod_t p;
		prod_t q;
		for (int n = 0; n < LANES; n++) begin
			code  = code_t'(codes_s1[CODE_W*(LANES-1-n) +: CODE_W]);
			scale = (code == CODE_NEG_I || code == CODE_POS_I) ? scale_im_s1 : scale_re_s1;
			p     = PROD_W'(re_s1[n]) * PROD_W'(scale);
			q     = PROD_W'(im_s1[n]) * PROD_W'(scale);
			unique case (code)
				CODE_NEG_ONE: begin
					re_c[n] = -p;
					im_c[n] = q;
				end
				CODE_POS_ONE: begin
					re_c[n] = p;
					im_c[n] = -q;
				end
				CODE_NEG_I: begin
					re_c[n] = -q;
					im_c[n] = -p;
				end
				CODE_POS_I: begin
					re_c[n] = q;
					im_c[n] = p;
				end
				default: begin
					re_c[n] = '0;
					im_c[n] = '0;
				end
			endcase
		end
	end

	// register the signed terms
	always_ff @(posedge clk) begin
		if (s2_en && valid_s1) begin
			last_s2 <= last_s1;
			re_s2   <= re_c;
			im_s2   <= im_c;
		end
	end

	assign terms.valid = valid_s2;
	assign terms.last  = last_s2;
	assign terms.re    = re_s2;
	assign terms.im    = im_s2;

endmodule

FILE: hdl/cqwd_accum.sv
`include "complex_quaternary_weight_dot_unit_macros.svh"

module cqwd_accum import cqwd_pkg::*; #(
	parameter int ACC_WIDTH = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	input  term_bus_t   terms,
	output logic        take,
	cqwd_result_if.source result
);

	typedef logic signed [ACC_WIDTH-1:0] acc_t;
	typedef logic signed [ACC_WIDTH:0]   wide_t;

	logic  valid_s3;
	logic  last_s3;
	tsum_t add_re_s3;
	tsum_t add_im_s3;
	tsum_t add_re_c;
	tsum_t add_im_c;

	acc_t  acc_re_q;
	acc_t  acc_im_q;
	wide_t wide_re_c;
	wide_t wide_im_c;
	acc_t  new_re_c;
	acc_t  new_im_c;

	logic  out_valid_q;
	sum_t  sum_re_q;
	sum_t  sum_im_q;

	logic  out_free;
	logic  s3_go;

	// clamp a one-bit-wider sum to the accumulator range
	function automatic acc_t sat(input wide_t v);
		acc_t r;
		if (v[ACC_WIDTH] != v[ACC_WIDTH-1]) begin
			r = v[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}} : {1'b0, {(ACC_WIDTH-1){1'b1}}};
		end else begin
			r = v[ACC_WIDTH-1:0];
		end
		return r;
	endfunction

	// a row-ending request waits only for a free result register
	assign out_free = !out_valid_q || result.ready;
	assign s3_go    = valid_s3 && (!last_s3 || out_free);
	assign take     = !valid_s3 || s3_go;

	// add the four terms of each part
	always_comb begin
		add_re_c = '0;
		add_im_c = '0;
		for (int n = 0; n < LANES; n++) begin
			add_re_c = add_re_c + TSUM_W'($signed(terms.re[n]));
			add_im_c = add_im_c + TSUM_W'($signed(terms.im[n]));
		end
	end

	// accumulate with saturation
	assign wide_re_c = (ACC_WIDTH+1)'(acc_re_q) + (ACC_WIDTH+1)'(add_re_s3);
	assign wide_im_c = (ACC_WIDTH+1)'(acc_im_q) + (ACC_WIDTH+1)'(add_im_s3);
	assign new_re_c  = sat(wide_re_c);
	assign new_im_c  = sat(wide_im_c);

	// control state and accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3    <= 1'b0;
			acc_re_q    <= '0;
			acc_im_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s3 <= terms.valid;
			end
			if (s3_go) begin
				if (last_s3) begin
					acc_re_q <= '0;
					acc_im_q <= '0;
				end else begin
					acc_re_q <= new_re_c;
					acc_im_q <= new_im_c;
				end
			end
			if (s3_go && last_s3) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold the term sums and the row result
	always_ff @(posedge clk) begin
		if (take && terms.valid) begin
			last_s3   <= terms.last;
			add_re_s3 <= add_re_c;
			add_im_s3 <= add_im_c;
		end
		if (s3_go && last_s3) begin
			sum_re_q <= OUT_W'(new_re_c);
			sum_im_q <= OUT_W'(new_im_c);
		end
	end

	assign result.valid  = out_valid_q;
	assign result.sum_re = sum_re_q;
	assign result.sum_im = sum_im_q;

	`CQWD_ASSERT_NEXT(a_row_clears_acc, s3_go && last_s3, acc_re_q == '0 && acc_im_q == '0, "accumulator not cleared after row result")
	`CQWD_ASSERT_NEXT(a_row_end_waits, valid_s3 && last_s3 && !out_free, valid_s3 && last_s3 && $stable(add_re_s3) && $stable(add_im_s3), "row-ending request lost while result blocked")
	`CQWD_ASSERT_SAME(a_result_from_row_end, $rose(out_valid_q), $past(valid_s3 && last_s3), "result shown without a row-ending request")

endmodule

FILE: bench/cqwd_row_checker.sv
`timescale 1ns / 100ps

module cqwd_row_checker import cqwd_pkg::*; #(
	parameter int ACC_WIDTH = 48
) (
	input  logic   clk,
	input  logic   arst_n,
	cqwd_item_if   item,
	cqwd_result_if result,
	output int     mismatches,
	output int     rows_pending,
	output int     rows_done
);

	localparam longint ACC_MAX = (longint'(1) <<< (ACC_WIDTH - 1)) - 1;
	localparam longint ACC_MIN = -ACC_MAX - 1;

	typedef struct {
		sum_t re;
		sum_t im;
	} row_sum_t;

	longint   acc_re;
	longint   acc_im;
	row_sum_t row_sums_due [$];

	initial begin
		mismatches   = 0;
		rows_pending = 0;
		rows_done    = 0;
		acc_re       = 0;
		acc_im       = 0;
	end

	// add one request's exact term sum, clamp to the accumulator range
	function automatic longint clamp_add(longint acc, longint delta);
		longint total;
		total = acc + delta;
		if (total > ACC_MAX)
			return ACC_MAX;
		if (total < ACC_MIN)
			return ACC_MIN;
		return total;
	endfunction

	// fold the accepted request into the row sum, queue the sum on a row end
	task automatic fold_request();
		act_t   re_v [LANES];
		act_t   im_v [LANES];
		longint d_re;
		longint d_im;
		longint r;
		longint m;
		longint sr;
		longint si;
		code_t  code;
		re_v = '{item.act_re0, item.act_re1, item.act_re2, item.act_re3};
		im_v = '{item.act_im0, item.act_im1, item.act_im2, item.act_im3};
		sr   = longint'(item.scale_re);
		si   = longint'(item.scale_im);
		d_re = 0;
		d_im = 0;
		for (int n = 0; n < LANES; n++) begin
			code = code_t'(item.weight_codes[CODES_W-1-CODE_W*n -: CODE_W]);
			r    = longint'(re_v[n]);
			m    = longint'(im_v[n]);
			case (code)
				CODE_NEG_ONE: begin
					d_re -= r * sr;
					d_im += m * sr;
				end
				CODE_POS_ONE: begin
					d_re += r * sr;
					d_im -= m * sr;
				end
				CODE_NEG_I: begin
					d_re -= m * si;
					d_im -= r * si;
				end
				default: begin
					d_re += m * si;
					d_im += r * si;
				end
			endcase
		end
		acc_re = clamp_add(acc_re, d_re);
		acc_im = clamp_add(acc_im, d_im);
		if (item.last_of_row) begin
			row_sums_due.push_back('{sum_t'(acc_re), sum_t'(acc_im)});
			acc_re = 0;
			acc_im = 0;
		end
	endtask

	task automatic note_mismatch(string field, sum_t want, sum_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("row %0d %s: expected %0d, got %0d", rows_done, field, want, got);
	endtask

	// compare results first, then take the request of the same edge
	always @(posedge clk) begin
		row_sum_t want;
		if (!arst_n) begin
			acc_re = 0;
			acc_im = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (row_sums_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("row sum %0d / %0d arrived with no row pending",
							result.sum_re, result.sum_im);
				end else begin
					want = row_sums_due.pop_front();
					if (result.sum_re !== want.re)
						note_mismatch("sum_re", want.re, result.sum_re);
					if (result.sum_im !== want.im)
						note_mismatch("sum_im", want.im, result.sum_im);
				end
				rows_done++;
			end
			if (item.valid && item.ready)
				fold_request();
		end
		rows_pending = row_sums_due.size();
	end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import cqwd_pkg::*;

	localparam int RANDOM_REQUESTS = 1800;
	// short full-scale runs: largest term sums in both directions
	localparam int FULL_RUN        = 12;
	localparam int DRAIN_LIMIT     = 5000;

	typedef struct {
		logic [CODES_W-1:0] codes;
		act_t               act [2*LANES];
		act_t               sc_re;
		act_t               sc_im;
		logic               last;
	} request_t;

	localparam act_t EXTREMES [6] = '{16'sh8000, 16'sh7FFF, 16'sh0000,
		16'shFFFF, 16'sh0001, 16'sh8001};
	localparam logic [CODES_W-1:0] DIRECTED_CODES [18] = '{8'h55, 8'h00, 8'hAA,
		8'hFF, 8'h1B, 8'hE4, 8'h27, 8'hD8, 8'h55, 8'h00, 8'hAA, 8'hFF, 8'h6C,
		8'h93, 8'hB1, 8'h4E, 8'hFF, 8'h00};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   mismatches;
	int   rows_pending;
	int   rows_done;
	int   requests_sent = 0;
	bit   pace_gaps = 1'b0;
	bit   ready_stalls = 1'b0;

	cqwd_item_if   item_ch ();
	cqwd_result_if result_ch ();

	complex_quaternary_weight_dot_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	cqwd_row_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item_ch),
		.result       (result_ch),
		.mismatches   (mismatches),
		.rows_pending (rows_pending),
		.rows_done    (rows_done)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 80)
			return $urandom_range(1, 3);
		if (pick < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic act_t random_act();
		if ($urandom_range(0, 99) < 12)
			return EXTREMES[$urandom_range(0, 5)];
		return act_t'($urandom);
	endfunction

	function automatic request_t random_request(logic last);
		request_t rq;
		rq.codes = CODES_W'($urandom);
		for (int k = 0; k < 2*LANES; k++)
			rq.act[k] = random_act();
		rq.sc_re = random_act();
		rq.sc_im = random_act();
		rq.last  = last;
		return rq;
	endfunction

	function automatic request_t full_scale_request(logic [CODES_W-1:0] codes, logic last);
		request_t rq;
		rq.codes = codes;
		for (int k = 0; k < 2*LANES; k++)
			rq.act[k] = 16'sh8000;
		rq.sc_re = 16'sh8000;
		rq.sc_im = 16'sh8000;
		rq.last  = last;
		return rq;
	endfunction

	// present one request at a falling edge and hold it until accepted
	task automatic send_request(request_t rq);
		int gap;
		gap = (pace_gaps && $urandom_range(0, 99) < 35) ? idle_len() : 0;
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.weight_codes <= rq.codes;
		item_ch.act_re0      <= rq.act[0];
		item_ch.act_im0      <= rq.act[1];
		item_ch.act_re1      <= rq.act[2];
		item_ch.act_im1      <= rq.act[3];
		item_ch.act_re2      <= rq.act[4];
		item_ch.act_im2      <= rq.act[5];
		item_ch.act_re3      <= rq.act[6];
		item_ch.act_im3      <= rq.act[7];
		item_ch.scale_re     <= rq.sc_re;
		item_ch.scale_im     <= rq.sc_im;
		item_ch.last_of_row  <= rq.last;
		item_ch.valid        <= 1'b1;
		do
			@(posedge clk);
		while (!item_ch.ready);
		requests_sent++;
		@(negedge clk);
	endtask

	// hold off new requests until every row sum has come back
	task automatic wait_rows_drained();
		item_ch.valid <= 1'b0;
		do
			@(negedge clk);
		while (rows_pending != 0);
	endtask

	// result side: random stalls on ready
	initial begin
		int hold;
		hold = 0;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				result_ch.ready <= 1'b0;
				hold--;
			end else begin
				result_ch.ready <= 1'b1;
				if (ready_stalls && $urandom_range(0, 99) < 25)
					hold = idle_len();
			end
		end
	end

	initial begin
		#24000000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		request_t rq;
		int       row_len;
		int       block_end;
		int       drain;
		int       failures;
		item_ch.valid        = 1'b0;
		item_ch.weight_codes = '0;
		item_ch.act_re0      = '0;
		item_ch.act_im0      = '0;
		item_ch.act_re1      = '0;
		item_ch.act_im1      = '0;
		item_ch.act_re2      = '0;
		item_ch.act_im2      = '0;
		item_ch.act_re3      = '0;
		item_ch.act_im3      = '0;
		item_ch.scale_re     = '0;
		item_ch.scale_im     = '0;
		item_ch.last_of_row  = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: both full negative operands, then every code over extreme values
		send_request(full_scale_request(8'h55, 1'b1));
		send_request(full_scale_request(8'hFF, 1'b1));
		for (int i = 0; i < 18; i++) begin
			rq.codes = DIRECTED_CODES[i];
			for (int k = 0; k < 2*LANES; k++)
				rq.act[k] = EXTREMES[(i + 3*k) % 6];
			rq.sc_re = EXTREMES[(2*i + 1) % 6];
			rq.sc_im = EXTREMES[(2*i + 4) % 6];
			rq.last  = (i == 0) || (i % 4 == 3) || (i == 17);
			send_request(rq);
		end
		wait_rows_drained();

		// random rows in blocks, each block with its own idling mix
		while (requests_sent < RANDOM_REQUESTS) begin
			pace_gaps    = $urandom_range(0, 2) != 0;
			ready_stalls = $urandom_range(0, 2) != 0;
			block_end    = requests_sent + 300;
			if (block_end > RANDOM_REQUESTS)
				block_end = RANDOM_REQUESTS;
			while (requests_sent < block_end) begin
				row_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
					: $urandom_range(1, 8);
				for (int j = 1; j <= row_len; j++)
					send_request(random_request(j == row_len));
			end
			wait_rows_drained();
		end

		// full-scale rows in both directions, then step back toward zero
		pace_gaps    = 1'b0;
		ready_stalls = 1'b0;
		repeat (FULL_RUN) send_request(full_scale_request(8'h55, 1'b0));
		repeat (3) send_request(full_scale_request(8'h00, 1'b0));
		send_request(full_scale_request(8'h00, 1'b1));
		repeat (FULL_RUN) send_request(full_scale_request(8'h00, 1'b0));
		repeat (3) send_request(full_scale_request(8'h55, 1'b0));
		send_request(full_scale_request(8'h55, 1'b1));
		item_ch.valid <= 1'b0;

		// drain, then allow for the pipeline depth
		drain = 0;
		while (rows_pending != 0 && drain < DRAIN_LIMIT) begin
			@(negedge clk);
			drain++;
		end
		repeat (8) @(negedge clk);
		failures = mismatches;
		if (rows_pending != 0) begin
			$display("%0d row sums never arrived", rows_pending);
			failures++;
		end
		$display("sent %0d requests, checked %0d row sums", requests_sent, rows_done);
		$display("covered extreme operands, all weight codes, random rows and full-scale rows");
		if (failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
